// File: rtl/core/lfu_pkg.sv
// Shared types for the LFU cache table: sequencer states and cell commands.
`timescale 1ns / 1ps

package lfu_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_EVICT,
        ST_INSERT,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TOUCH,
        OP_EVICT,
        OP_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     wr_value;
    } cell_ctl_t;

endpackage

// File: rtl/core/lfu_cell.sv
// One cache slot: key, value, use count and recency rank, plus one victim-search stage.
`timescale 1ns / 1ps

module lfu_cell #(
    parameter int KEY_W   = 32,
    parameter int COUNT_W = 16,
    parameter int RANK_W  = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lfu_pkg::cell_ctl_t  ctl,
    input  logic                sel,
    input  logic [RANK_W-1:0]   ref_rank,
    input  logic [KEY_W-1:0]    key_in,
    input  logic [KEY_W-1:0]    value_in,
    input  logic                cand_vld_in,
    input  logic [COUNT_W-1:0]  cand_cnt_in,
    input  logic [RANK_W-1:0]   cand_rank_in,
    input  logic [RANK_W-1:0]   cand_idx_in,
    output logic                valid,
    output logic                match,
    output logic [KEY_W-1:0]    key,
    output logic [KEY_W-1:0]    value,
    output logic [RANK_W-1:0]   rank,
    output logic                cand_vld_out,
    output logic [COUNT_W-1:0]  cand_cnt_out,
    output logic [RANK_W-1:0]   cand_rank_out,
    output logic [RANK_W-1:0]   cand_idx_out
);

    logic                valid_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [KEY_W-1:0]    value_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [RANK_W-1:0]   rank_reg;
    logic                cand_vld_reg;
    logic [COUNT_W-1:0]  cand_cnt_reg;
    logic [RANK_W-1:0]   cand_rank_reg;
    logic [RANK_W-1:0]   cand_idx_reg;
    logic                own_better;

    assign valid = valid_reg;
    assign key   = key_reg;
    assign value = value_reg;
    assign rank  = rank_reg;
    assign match = valid_reg && (key_reg == key_in);

    // Keep the smaller count; on a tie the older entry wins.
    assign own_better = valid_reg && (!cand_vld_in || (count_reg < cand_cnt_in) ||
                        ((count_reg == cand_cnt_in) && (rank_reg > cand_rank_in)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            if (sel && (ctl.op == lfu_pkg::OP_EVICT))
            begin
                valid_reg <= 1'b0;
            end
            else if (sel && (ctl.op == lfu_pkg::OP_INSERT))
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            lfu_pkg::OP_TOUCH:
            begin
                if (sel)
                begin
                    rank_reg <= '0;
                    if (count_reg != '1)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    if (ctl.wr_value)
                    begin
                        value_reg <= value_in;
                    end
                end
                else if (valid_reg && (rank_reg < ref_rank))
                begin
                    rank_reg <= rank_reg + 1'b1;
                end
            end
            lfu_pkg::OP_EVICT:
            begin
                if (!sel && valid_reg && (rank_reg > ref_rank))
                begin
                    rank_reg <= rank_reg - 1'b1;
                end
            end
            lfu_pkg::OP_INSERT:
            begin
                if (sel)
                begin
                    key_reg   <= key_in;
                    value_reg <= value_in;
                    count_reg <= COUNT_W'(1);
                    rank_reg  <= '0;
                end
                else if (valid_reg)
                begin
                    rank_reg <= rank_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Victim search stage: advance the best candidate one cell per cycle.
    always_ff @(posedge clk)
    begin
        if (own_better)
        begin
            cand_vld_reg  <= 1'b1;
            cand_cnt_reg  <= count_reg;
            cand_rank_reg <= rank_reg;
            cand_idx_reg  <= RANK_W'(CELL_IDX);
        end
        else
        begin
            cand_vld_reg  <= cand_vld_in;
            cand_cnt_reg  <= cand_cnt_in;
            cand_rank_reg <= cand_rank_in;
            cand_idx_reg  <= cand_idx_in;
        end
    end

    assign cand_vld_out  = cand_vld_reg;
    assign cand_cnt_out  = cand_cnt_reg;
    assign cand_rank_out = cand_rank_reg;
    assign cand_idx_out  = cand_idx_reg;

endmodule

// File: rtl/core/lfu_cache_table.sv
// Top level of the LFU cache table: sequencer, capacity register and the row of slot cells.
`timescale 1ns / 1ps
//
// Key-value cache with least-frequently-used replacement, oldest entry on a count tie.
// Input channel: in_valid/in_stall carries cmd (0 get, 1 put), key and value.
// Output channel: out_valid/out_stall carries hit, read_value, evicted, evicted_key,
// one result beat per input beat, in order.
// Configuration: cfg_wr_en/cfg_wr_data write the capacity register (0 acts as 1,
// values above TABLE_ENTRIES act as TABLE_ENTRIES); write only while idle.
// States from input beat to result beat:
//   get (hit or miss) and put on a present key: look, then respond,
//   put of a new key with room left: look, insert, respond,
//   put of a new key into a full table: look, scan, evict, insert, respond, the scan
//   covering the victim search that walks the cell chain one cell per cycle.
// One beat is processed at a time, so the next input beat is taken only once the
// sequencer is back in idle.
// in_stall is high until the beat's result is loaded into the output register,
// so the next beat enters while a result waits.
// Reset clears every slot to invalid and sets capacity to 16.
// A stalled result holds in the output register; the sequencer waits for it to drain
// before handing over the next result.

module lfu_cache_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int COUNT_BITS    = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [4:0]          cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cmd,
    input  logic signed [31:0]  key,
    input  logic signed [31:0]  value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                hit,
    output logic signed [31:0]  read_value,
    output logic                evicted,
    output logic signed [31:0]  evicted_key
);

    localparam int RW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int VCW  = $clog2(TABLE_ENTRIES + 1);
    localparam int CMPW = (VCW > 5) ? VCW : 5;
    localparam int SCW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    lfu_pkg::state_t      state_reg, state_next;
    logic [4:0]           cap_reg;
    logic [VCW-1:0]       vcnt_reg;
    logic [SCW-1:0]       scan_reg;
    logic                 cmd_reg;
    logic [31:0]          key_reg;
    logic [31:0]          value_reg;
    logic                 res_hit_reg;
    logic [31:0]          res_rd_reg;
    logic                 res_ev_reg;
    logic [31:0]          res_evk_reg;
    logic                 out_valid_reg;
    logic                 hit_out_reg;
    logic [31:0]          rd_out_reg;
    logic                 ev_out_reg;
    logic [31:0]          evk_out_reg;

    lfu_pkg::cell_ctl_t   ctl;
    logic [TABLE_ENTRIES-1:0] sel;
    logic [RW-1:0]        ref_rank;

    logic [TABLE_ENTRIES-1:0] cell_valid;
    logic [TABLE_ENTRIES-1:0] cell_match;
    logic [31:0]          cell_key   [TABLE_ENTRIES];
    logic [31:0]          cell_value [TABLE_ENTRIES];
    logic [RW-1:0]        cell_rank  [TABLE_ENTRIES];
    logic                 c_vld  [TABLE_ENTRIES+1];
    logic [COUNT_BITS-1:0] c_cnt [TABLE_ENTRIES+1];
    logic [RW-1:0]        c_rank [TABLE_ENTRIES+1];
    logic [RW-1:0]        c_idx  [TABLE_ENTRIES+1];

    logic                 any_match;
    logic [31:0]          match_value;
    logic [RW-1:0]        match_rank;
    logic [31:0]          victim_key;
    logic                 free_any;
    logic [RW-1:0]        free_idx;
    logic [CMPW-1:0]      eff_cap;
    logic                 full;
    logic                 resp_free;

    // Chain entry: no candidate yet.
    assign c_vld[0]  = 1'b0;
    assign c_cnt[0]  = '0;
    assign c_rank[0] = '0;
    assign c_idx[0]  = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        lfu_cell #(
            .KEY_W    (32),
            .COUNT_W  (COUNT_BITS),
            .RANK_W   (RW),
            .CELL_IDX (g)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (ctl),
            .sel           (sel[g]),
            .ref_rank      (ref_rank),
            .key_in        (key_reg),
            .value_in      (value_reg),
            .cand_vld_in   (c_vld[g]),
            .cand_cnt_in   (c_cnt[g]),
            .cand_rank_in  (c_rank[g]),
            .cand_idx_in   (c_idx[g]),
            .valid         (cell_valid[g]),
            .match         (cell_match[g]),
            .key           (cell_key[g]),
            .value         (cell_value[g]),
            .rank          (cell_rank[g]),
            .cand_vld_out  (c_vld[g+1]),
            .cand_cnt_out  (c_cnt[g+1]),
            .cand_rank_out (c_rank[g+1]),
            .cand_idx_out  (c_idx[g+1])
        );
    end

    // Keys are unique among valid slots, so at most one match: OR-select its fields.
    always_comb
    begin
        any_match   = 1'b0;
        match_value = '0;
        match_rank  = '0;
        victim_key  = '0;
        free_any    = 1'b0;
        free_idx    = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (cell_match[i])
            begin
                any_match   = 1'b1;
                match_value = match_value | cell_value[i];
                match_rank  = match_rank | cell_rank[i];
            end
            if (c_idx[TABLE_ENTRIES] == RW'(i))
            begin
                victim_key = cell_key[i];
            end
        end
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!cell_valid[i])
            begin
                free_any = 1'b1;
                free_idx = RW'(i);
            end
        end
    end

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CMPW'(1);
        end
        else if (CMPW'(cap_reg) > CMPW'(TABLE_ENTRIES))
        begin
            eff_cap = CMPW'(TABLE_ENTRIES);
        end
        else
        begin
            eff_cap = CMPW'(cap_reg);
        end
    end

    assign full      = CMPW'(vcnt_reg) >= eff_cap;
    assign resp_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != lfu_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer: next state and the command broadcast to the cells.
    always_comb
    begin
        state_next  = state_reg;
        ctl.op      = lfu_pkg::OP_NONE;
        ctl.wr_value = 1'b0;
        sel         = '0;
        ref_rank    = '0;
        unique case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lfu_pkg::ST_LOOK;
                end
            end
            lfu_pkg::ST_LOOK:
            begin
                if (any_match)
                begin
                    ctl.op       = lfu_pkg::OP_TOUCH;
                    ctl.wr_value = cmd_reg;
                    sel          = cell_match;
                    ref_rank     = match_rank;
                    state_next   = lfu_pkg::ST_RESP;
                end
                else if (!cmd_reg)
                begin
                    state_next = lfu_pkg::ST_RESP;
                end
                else if (full)
                begin
                    state_next = lfu_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = lfu_pkg::ST_INSERT;
                end
            end
            lfu_pkg::ST_SCAN:
            begin
                if (scan_reg == SCW'(TABLE_ENTRIES - 1))
                begin
                    state_next = lfu_pkg::ST_EVICT;
                end
            end
            lfu_pkg::ST_EVICT:
            begin
                if (c_vld[TABLE_ENTRIES])
                begin
                    ctl.op   = lfu_pkg::OP_EVICT;
                    ref_rank = c_rank[TABLE_ENTRIES];
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        sel[i] = (c_idx[TABLE_ENTRIES] == RW'(i));
                    end
                end
                state_next = lfu_pkg::ST_INSERT;
            end
            lfu_pkg::ST_INSERT:
            begin
                if (free_any)
                begin
                    ctl.op = lfu_pkg::OP_INSERT;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        sel[i] = (free_idx == RW'(i));
                    end
                end
                state_next = lfu_pkg::ST_RESP;
            end
            lfu_pkg::ST_RESP:
            begin
                if (resp_free)
                begin
                    state_next = lfu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    // Control counters, the capacity register and the output valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= 5'd16;
            vcnt_reg      <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if ((state_reg == lfu_pkg::ST_EVICT) && c_vld[TABLE_ENTRIES])
            begin
                vcnt_reg <= vcnt_reg - 1'b1;
            end
            else if ((state_reg == lfu_pkg::ST_INSERT) && free_any)
            begin
                vcnt_reg <= vcnt_reg + 1'b1;
            end
            if (state_reg == lfu_pkg::ST_SCAN)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            else
            begin
                scan_reg <= '0;
            end
            if ((state_reg == lfu_pkg::ST_RESP) && resp_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Beat capture, result build-up and the output register.
    always_ff @(posedge clk)
    begin
        if ((state_reg == lfu_pkg::ST_IDLE) && in_valid)
        begin
            cmd_reg   <= cmd;
            key_reg   <= key;
            value_reg <= value;
        end
        if (state_reg == lfu_pkg::ST_LOOK)
        begin
            res_hit_reg <= any_match;
            res_ev_reg  <= 1'b0;
            res_evk_reg <= '0;
            if (cmd_reg)
            begin
                res_rd_reg <= '0;
            end
            else if (any_match)
            begin
                res_rd_reg <= match_value;
            end
            else
            begin
                res_rd_reg <= '1;
            end
        end
        if ((state_reg == lfu_pkg::ST_EVICT) && c_vld[TABLE_ENTRIES])
        begin
            res_ev_reg  <= 1'b1;
            res_evk_reg <= victim_key;
        end
        if ((state_reg == lfu_pkg::ST_RESP) && resp_free)
        begin
            hit_out_reg <= res_hit_reg;
            rd_out_reg  <= res_rd_reg;
            ev_out_reg  <= res_ev_reg;
            evk_out_reg <= res_evk_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_out_reg;
    assign read_value  = rd_out_reg;
    assign evicted     = ev_out_reg;
    assign evicted_key = evk_out_reg;

    // The fill count tracks the slot valid bits exactly.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(vcnt_reg))
    else $error("fill count out of step with valid slots");

    // A full table always yields a victim at the end of the search.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfu_pkg::ST_EVICT) |-> c_vld[TABLE_ENTRIES])
    else $error("victim search found no candidate");

    // After an insert there is always at least one valid slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfu_pkg::ST_INSERT) |=> (cell_valid != '0))
    else $error("insert left the table empty");

    // A get miss never reports an eviction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfu_pkg::ST_RESP && !res_hit_reg && !cmd_reg) |-> !res_ev_reg)
    else $error("eviction on a get");

endmodule

// File: test/tb_lfu_cache_table.sv
// Self-checking testbench for the LFU cache table with LRU tiebreak.
`timescale 1ns / 1ps

module tb_lfu_cache_table;

    localparam int SLOTS     = 16;
    localparam int COUNT_TOP = 65535;
    localparam int LIMIT     = 400000;
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } lookup_t;

    // Scoreboard: shadow table of the cache plus a queue of expected results.
    class cache_scoreboard;
        bit          live[SLOTS];
        logic [31:0] tag[SLOTS];
        logic [31:0] data[SLOTS];
        int unsigned uses[SLOTS];
        int unsigned age[SLOTS];
        int unsigned cap_reg;
        lookup_t     pending[$];

        function void clear_table();
            for (int i = 0; i < SLOTS; i++) live[i] = 0;
            cap_reg = 16;
        endfunction

        function void refresh(int s);
            if (uses[s] < COUNT_TOP) uses[s]++;
            for (int j = 0; j < SLOTS; j++)
                if (live[j] && j != s && age[j] < age[s]) age[j]++;
            age[s] = 0;
        endfunction

        // Note an accepted input beat and queue its expected result.
        function void note_input(logic op, logic [31:0] k, logic [31:0] v);
            lookup_t r;
            int found, nlive, cap, victim, slot;
            int unsigned gone;
            found = -1; nlive = 0; victim = -1; slot = -1;
            r = '{1'b0, 32'h0, 1'b0, 32'h0};
            cap = (cap_reg < 1) ? 1 : (cap_reg > SLOTS ? SLOTS : cap_reg);
            for (int i = 0; i < SLOTS; i++)
                if (live[i])
                begin
                    nlive++;
                    if (found < 0 && tag[i] == k) found = i;
                end
            if (found >= 0)
            begin
                r.hit = 1;
                refresh(found);
                if (op == CMD_GET) r.read_value = data[found];
                else data[found] = v;
            end
            else if (op == CMD_GET)
                r.read_value = 32'hFFFF_FFFF;
            else
            begin
                if (nlive >= cap)
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (live[i] && (victim < 0 || uses[i] < uses[victim] ||
                            (uses[i] == uses[victim] && age[i] > age[victim])))
                            victim = i;
                    gone = age[victim];
                    r.evicted = 1;
                    r.evicted_key = tag[victim];
                    live[victim] = 0;
                    for (int i = 0; i < SLOTS; i++)
                        if (live[i] && age[i] > gone) age[i]--;
                end
                for (int i = 0; i < SLOTS && slot < 0; i++)
                    if (!live[i]) slot = i;
                for (int i = 0; i < SLOTS; i++)
                    if (live[i]) age[i]++;
                live[slot] = 1; tag[slot] = k; data[slot] = v;
                uses[slot] = 1; age[slot] = 0;
            end
            pending.push_back(r);
        endfunction

        // Compare one result beat against the oldest expectation.
        task check_result(lookup_t got);
            lookup_t w;
            if (pending.size() == 0)
            begin
                report_mismatch("result beat with nothing expected");
                return;
            end
            w = pending.pop_front();
            if (got.hit !== w.hit)
                report_mismatch($sformatf("hit %0b want %0b", got.hit, w.hit));
            if (got.read_value !== w.read_value)
                report_mismatch($sformatf("read_value %h want %h",
                                          got.read_value, w.read_value));
            if (got.evicted !== w.evicted)
                report_mismatch($sformatf("evicted %0b want %0b", got.evicted, w.evicted));
            if (got.evicted_key !== w.evicted_key)
                report_mismatch($sformatf("evicted_key %h want %h",
                                          got.evicted_key, w.evicted_key));
        endtask
    endclass

    logic        clk, rst_n;
    logic        cfg_wr_en;
    logic [4:0]  cfg_wr_data;
    logic        in_valid, in_stall, cmd;
    logic signed [31:0] key, value;
    logic        out_valid, out_stall, hit, evicted;
    logic signed [31:0] read_value, evicted_key;

    int          errors;
    int unsigned cycles = 0;
    int          send_idle_pct, recv_stall_pct;
    cache_scoreboard sb;
    logic [31:0] key_pool[8];

    lfu_cache_table dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .key(key), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .read_value(read_value),
        .evicted(evicted), .evicted_key(evicted_key)
    );

    task automatic report_mismatch(string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Watchdog: end the run if the cycle count runs away.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: randomly stall and check every accepted result beat.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{hit, read_value, evicted, evicted_key});
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Drive one input beat, with random idle cycles ahead of it; hold until accepted.
    // Valid stays up after the accept; the next beat, an idle cycle or drain drops it.
    task automatic send_beat(logic op, logic [31:0] k, logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1; cmd <= op; key <= k; value <= v;
        do @(posedge clk); while (in_stall);
        sb.note_input(op, k, v);
    endtask

    // Drain every expected result, then let the block settle before a config write.
    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);
    endtask

    task automatic write_capacity(logic [4:0] c);
        drain();
        cfg_wr_en <= 1; cfg_wr_data <= c;
        @(posedge clk);
        cfg_wr_en <= 0;
        sb.cap_reg = c;
    endtask

    function automatic logic [31:0] pick_key();
        return ($urandom_range(3) == 0) ? $urandom() : key_pool[3'($urandom_range(7))];
    endfunction

    task automatic random_burst(int n);
        for (int i = 0; i < n; i++)
            send_beat(1'($urandom_range(1)), pick_key(), $urandom());
    endtask

    initial
    begin
        errors = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        sb = new();
        sb.clear_table();
        rst_n = 0; cfg_wr_en = 0; cfg_wr_data = 0;
        in_valid = 0; cmd = 0; key = 0; value = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: misses, extremes, update, saturation-free hits, eviction with ties.
        send_beat(CMD_GET, 32'h0, 32'h0);
        send_beat(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_beat(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_beat(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_GET, 32'h8000_0000, 32'h1234_5678);
        send_beat(CMD_PUT, 32'h7FFF_FFFF, 32'h0);
        send_beat(CMD_GET, 32'h7FFF_FFFF, 32'h0);
        send_beat(CMD_GET, 32'h5555_5555, 32'h0);
        write_capacity(5'd2);              // lowered below the valid count
        send_beat(CMD_PUT, 32'h0000_0001, 32'hAAAA_AAAA);
        send_beat(CMD_PUT, 32'h0000_0002, 32'h5555_5555);
        send_beat(CMD_PUT, 32'h0000_0003, 32'h1);
        send_beat(CMD_GET, 32'h0000_0002, 32'h0);
        send_beat(CMD_PUT, 32'h0000_0004, 32'h2);
        write_capacity(5'd0);              // zero acts as one
        send_beat(CMD_PUT, 32'h0000_0005, 32'h3);
        send_beat(CMD_PUT, 32'h0000_0006, 32'h4);
        send_beat(CMD_GET, 32'h0000_0006, 32'h0);
        write_capacity(5'd31);             // above table size
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom();

        // Random phases across capacities and idling profiles.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            if (ph == 4) write_capacity(5'd16);
            else if (ph > 0) write_capacity(5'($urandom_range(31)));
            for (int i = 0; i < 8; i++)
                if ($urandom_range(1)) key_pool[i] = $urandom();
            random_burst(28);
            drain();                       // sender holds until all results are in
            random_burst(28);
        end

        drain();
        recv_stall_pct = 0;
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
